FILE: rtl/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and the symbol map of the base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

   localparam int CHAR_W      = 8;
   localparam int SYM_W       = 5;
   localparam int COUNT_W     = 4;
   localparam int HELD_W      = 4;
   localparam int ACC_W       = 7;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0]  CHAR_Z     = 8'h5A;
   localparam logic [CHAR_W-1:0]  CHAR_2     = 8'h32;
   localparam logic [CHAR_W-1:0]  CHAR_7     = 8'h37;
   localparam logic [CHAR_W-1:0]  PAD_RESET  = 8'h39;
   localparam logic [COUNT_W-1:0] SKIP_RESET = 4'd4;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
   localparam logic [HELD_W-1:0]  BYTE_BITS  = 4'd8;
   localparam logic [HELD_W-1:0]  SYM_BITS   = 4'd5;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_SKIP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_CHAR    = 2'd1;

   typedef struct packed {
      logic              byte_valid;
      logic [CHAR_W-1:0] data_byte;
      logic              bad_char;
      logic              chunk_end;
   } rsp_type;

   typedef struct packed {
      logic             bad;
      logic [SYM_W-1:0] value;
   } sym_type;

   // Map one character to its 5-bit value; the pad character wins over the alphabet
   function automatic sym_type sym_map(input logic [CHAR_W-1:0] c,
                                       input logic [CHAR_W-1:0] pad);
      sym_type s;
      logic [CHAR_W-1:0] diff;
      s    = '0;
      diff = '0;
      if (c == pad) begin
         s.value = '0;
      end else if (c >= CHAR_A && c <= CHAR_Z) begin
         diff    = c - CHAR_A;
         s.value = diff[SYM_W-1:0];
      end else if (c >= CHAR_2 && c <= CHAR_7) begin
         diff    = c - CHAR_2 + 8'd26;
         s.value = diff[SYM_W-1:0];
      end else begin
         s.bad = 1'b1;
      end
      return s;
   endfunction

endpackage

FILE: rtl/b32d_unpack.sv
// ----------------------------------------------------------------------------
// b32d_unpack
// Per-chunk state (prefix counter, bit accumulator) and the one-character
// decode step that produces the result for the character presented.
// ----------------------------------------------------------------------------
module b32d_unpack
   import b32d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [CHAR_W-1:0]  char_code,
   input  logic               last_char,
   input  logic [COUNT_W-1:0] prefix_skip,
   input  logic [CHAR_W-1:0]  pad_char,
   output rsp_type            result
);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;

   sym_type            sym;
   logic [11:0]        joined;
   logic [HELD_W-1:0]  sum;
   logic [HELD_W-1:0]  held_dec;
   logic [ACC_W-1:0]   keep_mask;
   logic [11:0]        shifted;
   logic               skipping;

   always_comb begin
      sym       = sym_map(char_code, pad_char);
      skipping  = (seen_ff < prefix_skip);
      joined    = {acc_ff, sym.value};
      sum       = held_ff + SYM_BITS;
      held_dec  = (sum >= BYTE_BITS) ? (sum - BYTE_BITS) : sum;
      shifted   = joined >> held_dec;
      keep_mask = ACC_W'((8'd1 << held_dec) - 8'd1);

      result            = '0;
      result.chunk_end  = last_char;
      acc_in            = acc_ff;
      held_in           = held_ff;
      seen_in           = seen_ff;

      if (skipping) begin
         seen_in = seen_ff + 4'd1;
      end else begin
         result.bad_char = sym.bad;
         if (seen_ff != COUNT_MAX) begin
            seen_in = seen_ff + 4'd1;
         end
         held_in = held_dec;
         acc_in  = joined[ACC_W-1:0] & keep_mask;
         if (sum >= BYTE_BITS) begin
            result.byte_valid = 1'b1;
            result.data_byte  = shifted[CHAR_W-1:0];
         end
      end

      // drop leftover bits at chunk end
      if (last_char) begin
         acc_in  = '0;
         held_in = '0;
         seen_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
         seen_ff <= '0;
      end else if (step) begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
         seen_ff <= seen_in;
      end
   end

endmodule

FILE: rtl/base32_stream_decoder.sv
// ----------------------------------------------------------------------------
// base32_stream_decoder
// Streaming base32 (A-Z, 2-7) character decoder with per-chunk prefix skip.
// ----------------------------------------------------------------------------
// One character is taken per beat and every character yields exactly one
// result beat, at a sustained rate of one character per clock unless the
// sink stalls. The decode step (symbol lookup, 5-bit shift into the
// accumulator, byte extraction) sits between the accumulator state and the
// result register; a second result register absorbs one beat when the sink
// stalls, so the input stays ready until two results are waiting. tlast on
// the input ends a chunk: leftover bits are dropped and the prefix counter
// restarts. Write prefix_skip (index 0) and pad_char (index 1) only while idle.
module base32_stream_decoder
   import b32d_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] char_code
   input  logic                   req_tlast,   // last_char
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] data_byte
   output logic [1:0]             rsp_tuser,   // [0] byte_valid, [1] bad_char
   output logic                   rsp_tlast,   // chunk_end
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic [COUNT_W-1:0] skip_ff;
   logic [CHAR_W-1:0]  pad_ff;

   rsp_type result;
   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    accept, take;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= SKIP_RESET;
         pad_ff  <= PAD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PREFIX_SKIP: skip_ff <= csr_data[COUNT_W-1:0];
            CSR_PAD_CHAR:    pad_ff  <= csr_data;
            default:         ;
         endcase
      end
   end

   b32d_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .char_code   (req_tdata),
      .last_char   (req_tlast),
      .prefix_skip (skip_ff),
      .pad_char    (pad_ff),
      .result      (result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (!out_valid_ff) begin
         if (accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end else if (accept) begin
         // hold the stalled beat, park the new one
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data_byte;
   assign rsp_tuser  = {out_ff.bad_char, out_ff.byte_valid};
   assign rsp_tlast  = out_ff.chunk_end;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat held without a front beat");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.byte_valid) |-> (out_ff.data_byte == '0))
      else $error("data byte nonzero without byte_valid");

   a_accept_yields: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted beat produced no result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result changed");
`endif

endmodule
